FILE: rtl/core/kmp_pattern_matcher_assert.svh
// Assertion macros for the pattern matcher, sampled on the block clock.
`ifndef KMP_PATTERN_MATCHER_ASSERT_SVH
`define KMP_PATTERN_MATCHER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define KMP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define KMP_ASSERT_IMPLY(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

FILE: rtl/core/kmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

    localparam int MAX_PATTERN   = 1024;
    localparam int IDX_W         = $clog2(MAX_PATTERN);
    localparam int LEN_W         = IDX_W + 1;
    localparam int POSITION_BITS = 32;
    localparam int CHAR_W        = 8;
    localparam int OUT_W         = 32;

    localparam int TDATA_IN_W  = CHAR_W;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 2 * OUT_W;

    localparam int TUSER_FUNC_BIT  = 0;
    localparam int TUSER_FIRST_BIT = 1;

    typedef enum logic [0:0] {
        FUNC_PATTERN = 1'b0,
        FUNC_TEXT    = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PCMP,
        S_FLINK,
        S_MATCH,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/kmp_pattern_matcher.sv
// Pattern byte: handled in S_IDLE alone when it starts a pattern or is dropped, else it goes
// through S_PCMP, plus S_FLINK and S_PCMP again per link step. Text byte: S_IDLE alone with an
// empty pattern, else the same, then on a match S_MATCH and, while the output stalls, S_EMIT.
// One item at a time: the pattern store read and the byte compare are shared by all steps.
// Synchronous active-low reset clears the lengths, prefixes, position, count and output valid;
// the pattern and failure stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module kmp_pattern_matcher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kmp_pkg::TDATA_IN_W-1:0]   s_axis_tdata,  // byte_value
    input  logic [kmp_pkg::TUSER_IN_W-1:0]   s_axis_tuser,  // func, first
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [kmp_pkg::TDATA_OUT_W-1:0]  m_axis_tdata   // match_start, match_count
);

    import kmp_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [CHAR_W-1:0]        r_pstore [MAX_PATTERN];
    logic [IDX_W-1:0]         r_fstore [MAX_PATTERN];
    logic [CHAR_W-1:0]        r_p_rdata;
    logic [IDX_W-1:0]         r_f_rdata;

    logic [LEN_W-1:0]         r_len;
    logic [IDX_W-1:0]         r_bp;
    logic [IDX_W-1:0]         r_mp;
    logic [IDX_W-1:0]         r_k;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_cur_pos;
    logic [POSITION_BITS-1:0] r_start;
    logic [OUT_W-1:0]         r_count;
    t_func                    r_func;
    logic [CHAR_W-1:0]        r_ch;

    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_start;
    logic [OUT_W-1:0]         r_out_count;

    t_func                    in_func;
    logic                     in_first;
    logic                     accept;
    logic [LEN_W-1:0]         eff_len;
    logic                     full;
    logic [IDX_W-1:0]         text_k;
    logic                     starts;
    logic                     cmp_eq;
    logic                     link;
    logic                     is_end;
    logic [IDX_W-1:0]         newk;
    logic                     out_free;
    logic                     out_load;

    logic [IDX_W-1:0]         p_addr;
    logic [IDX_W-1:0]         f_addr;
    logic                     p_we;
    logic                     f_we;
    logic [IDX_W-1:0]         f_waddr;
    logic [IDX_W-1:0]         f_wdata;

    assign in_func  = t_func'(s_axis_tuser[TUSER_FUNC_BIT]);
    assign in_first = s_axis_tuser[TUSER_FIRST_BIT];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign eff_len  = in_first ? '0 : r_len;
    assign full     = (eff_len == LEN_W'(MAX_PATTERN));
    assign text_k   = in_first ? '0 : r_mp;
    assign starts   = (in_func == FUNC_TEXT) ? (r_len != '0) : (!full && (eff_len != '0));
    assign cmp_eq   = (r_p_rdata == r_ch);
    assign link     = (r_k != '0) && !cmp_eq;
    assign is_end   = cmp_eq && ({1'b0, r_k} == (r_len - LEN_W'(1)));
    assign newk     = cmp_eq ? (r_k + IDX_W'(1)) : r_k;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && starts) begin
                    n_state = S_PCMP;
                end
            end
            S_PCMP: begin
                priority if (link) begin
                    n_state = S_FLINK;
                end else if ((r_func == FUNC_TEXT) && is_end) begin
                    n_state = S_MATCH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FLINK: begin
                n_state = S_PCMP;
            end
            S_MATCH, S_EMIT: begin
                n_state = out_free ? S_IDLE : S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        p_addr        = r_k;
        f_addr        = r_k;
        p_we          = 1'b0;
        f_we          = 1'b0;
        f_waddr       = r_len[IDX_W-1:0];
        f_wdata       = newk;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                p_addr        = (in_func == FUNC_TEXT) ? text_k : r_bp;
                if (accept && (in_func == FUNC_PATTERN) && !full) begin
                    p_we = 1'b1;
                    if (eff_len == '0) begin
                        f_we    = 1'b1;
                        f_waddr = '0;
                        f_wdata = '0;
                    end
                end
            end
            S_PCMP: begin
                f_addr = link ? (r_k - IDX_W'(1)) : r_k;
                f_we   = !link && (r_func == FUNC_PATTERN);
            end
            S_FLINK: begin
                p_addr = r_f_rdata;
            end
            S_MATCH, S_EMIT: begin
                out_load = out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pstore[eff_len[IDX_W-1:0]] <= s_axis_tdata;
        end
        r_p_rdata <= r_pstore[p_addr];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fstore[f_waddr] <= f_wdata;
        end
        r_f_rdata <= r_fstore[f_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= in_func;
            r_ch      <= s_axis_tdata;
            r_k       <= (in_func == FUNC_TEXT) ? text_k : r_bp;
            r_cur_pos <= in_first ? '0 : r_pos;
        end else if (r_state == S_FLINK) begin
            r_k <= r_f_rdata;
        end
        if ((r_state == S_PCMP) && (r_func == FUNC_TEXT) && !link && is_end) begin
            r_start <= r_cur_pos - POSITION_BITS'(r_len) + POSITION_BITS'(1);
        end
        if (out_load) begin
            r_out_start <= OUT_W'(r_start);
            r_out_count <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_bp        <= '0;
            r_mp        <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && (in_func == FUNC_PATTERN)) begin
                if (in_first) begin
                    r_len <= '0;
                    r_bp  <= '0;
                    r_mp  <= '0;
                end
                if (!full && (eff_len == '0)) begin
                    r_len <= LEN_W'(1);
                    r_bp  <= '0;
                end
            end
            if (accept && (in_func == FUNC_TEXT)) begin
                r_pos <= (in_first ? '0 : r_pos) + POSITION_BITS'(1);
                if (in_first) begin
                    r_count <= '0;
                    r_mp    <= '0;
                end
            end
            if ((r_state == S_PCMP) && !link) begin
                if (r_func == FUNC_PATTERN) begin
                    r_bp  <= newk;
                    r_len <= r_len + LEN_W'(1);
                end else if (is_end) begin
                    r_count <= r_count + OUT_W'(1);
                end else begin
                    r_mp <= newk;
                end
            end
            if (r_state == S_MATCH) begin
                r_mp <= r_f_rdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_start};

    `include "kmp_pattern_matcher_assert.svh"

    `KMP_ASSERT_ALWAYS(a_prefix_in_pattern, (r_mp == '0) || ({1'b0, r_mp} < r_len), "match prefix beyond pattern")
    `KMP_ASSERT_ALWAYS(a_len_bounded, r_len <= LEN_W'(MAX_PATTERN), "pattern length beyond capacity")
    `KMP_ASSERT_IMPLY(a_match_full, r_state == S_MATCH, {1'b0, r_k} == (r_len - LEN_W'(1)), "match reported before the whole pattern")

endmodule

`default_nettype wire
